[rtl/core/psfp_pkg.sv]
// Shared types, constants and helpers for the particulate sensor frame parser.
// No dependencies; every other file refers to it by scoped names.
package psfp_pkg;

  // Frame framing constants
  localparam logic [7:0]  StartFirst  = 8'h42;
  localparam logic [7:0]  StartSecond = 8'h4D;
  localparam logic [15:0] GoodLength  = 16'h001C;
  localparam logic [7:0]  NoError     = 8'h00;
  localparam int unsigned FrameBytes  = 32;

  // Fixed byte positions inside a frame
  localparam logic [4:0] PosLenHigh = 5'd2;
  localparam logic [4:0] PosLenLow  = 5'd3;
  localparam logic [4:0] PosErr     = 5'd29;
  localparam logic [4:0] PosSumHigh = 5'd30;
  localparam logic [4:0] PosLast    = 5'(FrameBytes - 1);
  localparam logic [4:0] PosFirstData = 5'd2;

  // Sum of the two start bytes, the running sum at the start of collection
  localparam logic [15:0] StartSum = 16'(StartFirst) + 16'(StartSecond);

  // Offset register reset values
  localparam logic [4:0] FirstOffsetRst  = 5'd10;
  localparam logic [4:0] SecondOffsetRst = 5'd12;
  localparam logic [4:0] ThirdOffsetRst  = 5'd14;

  // Configuration register indexes
  localparam logic [1:0] CfgFirstOffset  = 2'd0;
  localparam logic [1:0] CfgSecondOffset = 2'd1;
  localparam logic [1:0] CfgThirdOffset  = 2'd2;

  typedef enum logic [1:0] {
    MODE_HUNT    = 2'd0,
    MODE_WAIT    = 2'd1,
    MODE_COLLECT = 2'd2
  } psfp_mode_e;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_BAD_LENGTH = 2'd1,
    STATUS_BAD_SUM    = 2'd2,
    STATUS_SENSOR_ERR = 2'd3
  } psfp_status_e;

  // Value offsets as seen by the parser core
  typedef struct packed {
    logic [4:0] first_off;
    logic [4:0] second_off;
    logic [4:0] third_off;
  } psfp_cfg_t;

  // Registered input byte
  typedef struct packed {
    logic       vld;
    logic [7:0] data;
  } psfp_item_t;

  // One parsed frame result
  typedef struct packed {
    psfp_status_e status;
    logic [15:0]  first_value;
    logic [15:0]  second_value;
    logic [15:0]  third_value;
  } psfp_result_t;

  // Merge byte b into a big-endian capture whose high byte sits at offset off.
  // The low byte compare is one bit wider so offset 31 never matches.
  function automatic logic [15:0] take_byte(logic [15:0] cap, logic [4:0] off,
                                            logic [4:0] pos, logic [7:0] b);
    logic [15:0] res;
    res = cap;
    if (pos == off) res[15:8] = b;
    if ({1'b0, pos} == ({1'b0, off} + 6'd1)) res[7:0] = b;
    return res;
  endfunction

endpackage

[rtl/core/particle_sensor_frame_parser_unit.sv]
// Top level of the particulate sensor 32-byte frame parser.
// Depends on psfp_pkg, psfp_cfg_regs, psfp_in_stage and psfp_frame_core.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o / rx_byte_i) carries one received
//   link byte per transaction. The parser hunts for the start pair 0x42 0x4D,
//   collects a 32-byte frame and, after byte 31, issues one transaction on the
//   output channel (out_valid_o / out_ready_i) with frame_status_o and three
//   big-endian readings; readings are zero unless the status is ok.
//   Configuration channel (cfg_valid_i / cfg_ready_o / cfg_index_i /
//   cfg_wdata_i) sets the byte offsets of the three readings (index 0..2);
//   other indexes are ignored. cfg_ready_o is always high. Write it only
//   while the parser is idle.
//   Throughput: one byte per cycle while no result waits on out_ready_i, set by
//   the single input register feeding the combinational parse logic. A frame's
//   last byte goes from the input register into the result register.
//   Stall: while a result waits on out_ready_i, the input register can still
//   take one byte and holds it; in_ready_o then stays low. Input resumes the
//   cycle the result leaves.
//   Reset: offsets return to 10, 12, 14, the parser hunts for a start byte
//   and both registers are empty.
module particle_sensor_frame_parser_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [4:0]  cfg_wdata_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  frame_status_o,
  output logic [15:0] first_value_o,
  output logic [15:0] second_value_o,
  output logic [15:0] third_value_o
);

  psfp_pkg::psfp_cfg_t    cfg;
  psfp_pkg::psfp_item_t   item;
  psfp_pkg::psfp_result_t result;
  logic                   take;

  psfp_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  psfp_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .rx_byte_i  (rx_byte_i),
    .take_i     (take),
    .item_o     (item)
  );

  psfp_frame_core u_frame_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item),
    .take_o      (take),
    .cfg_i       (cfg),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (result)
  );

  // Result fields onto their ports
  assign frame_status_o = 2'(result.status);
  assign first_value_o  = result.first_value;
  assign second_value_o = result.second_value;
  assign third_value_o  = result.third_value;

endmodule

[rtl/core/psfp_cfg_regs.sv]
// Offset configuration registers of the frame parser.
// Depends on psfp_pkg for reset values, register indexes and psfp_cfg_t.
module psfp_cfg_regs (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [4:0]         cfg_wdata_i,
  output psfp_pkg::psfp_cfg_t cfg_o
);

  logic [4:0] first_q, first_d;
  logic [4:0] second_q, second_d;
  logic [4:0] third_q, third_d;

  // Writes are always taken
  assign cfg_ready_o = 1'b1;

  // Register index decode; unknown indexes are ignored
  always_comb begin
    first_d  = first_q;
    second_d = second_q;
    third_d  = third_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        psfp_pkg::CfgFirstOffset:  first_d  = cfg_wdata_i;
        psfp_pkg::CfgSecondOffset: second_d = cfg_wdata_i;
        psfp_pkg::CfgThirdOffset:  third_d  = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q  <= psfp_pkg::FirstOffsetRst;
      second_q <= psfp_pkg::SecondOffsetRst;
      third_q  <= psfp_pkg::ThirdOffsetRst;
    end else begin
      first_q  <= first_d;
      second_q <= second_d;
      third_q  <= third_d;
    end
  end

  assign cfg_o = '{first_off: first_q, second_off: second_q, third_off: third_q};

endmodule

[rtl/core/psfp_in_stage.sv]
// Input register of the frame parser: holds one received byte until the core takes it.
// Depends on psfp_pkg for psfp_item_t.
module psfp_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          rx_byte_i,
  input  logic                take_i,
  output psfp_pkg::psfp_item_t item_o
);

  logic       vld_q, vld_d;
  logic [7:0] data_q, data_d;

  // Accept while empty or while the held byte moves on this cycle
  assign in_ready_o = !vld_q || take_i;

  always_comb begin
    vld_d  = vld_q;
    data_d = data_q;
    if (in_ready_o) begin
      vld_d  = in_valid_i;
      data_d = rx_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign item_o = '{vld: vld_q, data: data_q};

endmodule

[rtl/core/psfp_frame_core.sv]
// Frame parser core: start-byte hunt, 32-byte collection, checks and result register.
// Depends on psfp_pkg for modes, status codes, structs and take_byte.
module psfp_frame_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  psfp_pkg::psfp_item_t  item_i,
  output logic                  take_o,
  input  psfp_pkg::psfp_cfg_t   cfg_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output psfp_pkg::psfp_result_t result_o
);

  psfp_pkg::psfp_mode_e mode_q, mode_d;
  logic [4:0]  pos_q, pos_d;
  logic [15:0] sum_q, sum_d;
  logic [15:0] len_q, len_d;
  logic [7:0]  err_q, err_d;
  logic [7:0]  ckh_q, ckh_d;
  logic [15:0] cap1_q, cap1_d;
  logic [15:0] cap2_q, cap2_d;
  logic [15:0] cap3_q, cap3_d;
  logic        out_vld_q, out_vld_d;
  psfp_pkg::psfp_result_t res_q, res_d;

  logic [7:0]  b;
  logic        emit;
  logic [15:0] check;
  psfp_pkg::psfp_status_e status;

  assign b = item_i.data;

  // Process the held byte when the result register can take a result
  assign take_o = item_i.vld && (!out_vld_q || out_ready_i);

  // Last byte of a frame
  assign emit = take_o && (mode_q == psfp_pkg::MODE_COLLECT) && (pos_q == psfp_pkg::PosLast);

  // Next parse mode
  always_comb begin
    mode_d = mode_q;
    if (take_o) begin
      unique case (mode_q)
        psfp_pkg::MODE_HUNT: begin
          if (b == psfp_pkg::StartFirst) mode_d = psfp_pkg::MODE_WAIT;
        end
        psfp_pkg::MODE_WAIT: begin
          if (b == psfp_pkg::StartSecond) mode_d = psfp_pkg::MODE_COLLECT;
          else if (b != psfp_pkg::StartFirst) mode_d = psfp_pkg::MODE_HUNT;
        end
        psfp_pkg::MODE_COLLECT: begin
          if (pos_q == psfp_pkg::PosLast) mode_d = psfp_pkg::MODE_HUNT;
        end
        default: mode_d = psfp_pkg::MODE_HUNT;
      endcase
    end
  end

  // Frame datapath: position, sum, header fields and captures
  always_comb begin
    pos_d  = pos_q;
    sum_d  = sum_q;
    len_d  = len_q;
    err_d  = err_q;
    ckh_d  = ckh_q;
    cap1_d = cap1_q;
    cap2_d = cap2_q;
    cap3_d = cap3_q;
    if (take_o) begin
      unique case (mode_q)
        psfp_pkg::MODE_HUNT: ;
        psfp_pkg::MODE_WAIT: begin
          if (b == psfp_pkg::StartSecond) begin
            // Fresh frame: start bytes count as positions 0 and 1
            cap1_d = psfp_pkg::take_byte(psfp_pkg::take_byte(16'h0000, cfg_i.first_off,
                       5'd0, psfp_pkg::StartFirst), cfg_i.first_off, 5'd1,
                       psfp_pkg::StartSecond);
            cap2_d = psfp_pkg::take_byte(psfp_pkg::take_byte(16'h0000, cfg_i.second_off,
                       5'd0, psfp_pkg::StartFirst), cfg_i.second_off, 5'd1,
                       psfp_pkg::StartSecond);
            cap3_d = psfp_pkg::take_byte(psfp_pkg::take_byte(16'h0000, cfg_i.third_off,
                       5'd0, psfp_pkg::StartFirst), cfg_i.third_off, 5'd1,
                       psfp_pkg::StartSecond);
            sum_d = psfp_pkg::StartSum;
            len_d = '0;
            err_d = '0;
            ckh_d = '0;
            pos_d = psfp_pkg::PosFirstData;
          end
        end
        psfp_pkg::MODE_COLLECT: begin
          cap1_d = psfp_pkg::take_byte(cap1_q, cfg_i.first_off, pos_q, b);
          cap2_d = psfp_pkg::take_byte(cap2_q, cfg_i.second_off, pos_q, b);
          cap3_d = psfp_pkg::take_byte(cap3_q, cfg_i.third_off, pos_q, b);
          if (pos_q <= psfp_pkg::PosErr) sum_d = sum_q + 16'(b);
          if (pos_q == psfp_pkg::PosLenHigh) len_d[15:8] = b;
          else if (pos_q == psfp_pkg::PosLenLow) len_d[7:0] = b;
          else if (pos_q == psfp_pkg::PosErr) err_d = b;
          else if (pos_q == psfp_pkg::PosSumHigh) ckh_d = b;
          if (pos_q == psfp_pkg::PosLast) pos_d = '0;
          else pos_d = pos_q + 5'd1;
        end
        default: pos_d = '0;
      endcase
    end
  end

  // Frame checks in priority order: length, checksum, sensor error
  assign check = {ckh_q, b};

  always_comb begin
    if (len_q != psfp_pkg::GoodLength) status = psfp_pkg::STATUS_BAD_LENGTH;
    else if (sum_q != check) status = psfp_pkg::STATUS_BAD_SUM;
    else if (err_q != psfp_pkg::NoError) status = psfp_pkg::STATUS_SENSOR_ERR;
    else status = psfp_pkg::STATUS_OK;
  end

  // Result register
  always_comb begin
    out_vld_d = out_vld_q;
    res_d     = res_q;
    if (emit) begin
      out_vld_d = 1'b1;
      res_d.status = status;
      if (status == psfp_pkg::STATUS_OK) begin
        res_d.first_value  = cap1_d;
        res_d.second_value = cap2_d;
        res_d.third_value  = cap3_d;
      end else begin
        res_d.first_value  = '0;
        res_d.second_value = '0;
        res_d.third_value  = '0;
      end
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= psfp_pkg::MODE_HUNT;
      pos_q     <= '0;
      sum_q     <= '0;
      len_q     <= '0;
      err_q     <= '0;
      ckh_q     <= '0;
      cap1_q    <= '0;
      cap2_q    <= '0;
      cap3_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      mode_q    <= mode_d;
      pos_q     <= pos_d;
      sum_q     <= sum_d;
      len_q     <= len_d;
      err_q     <= err_d;
      ckh_q     <= ckh_d;
      cap1_q    <= cap1_d;
      cap2_q    <= cap2_d;
      cap3_q    <= cap3_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o = out_vld_q;
  assign result_o    = res_q;

  // A new result only follows the last byte of a frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(mode_q == psfp_pkg::MODE_COLLECT && pos_q == psfp_pkg::PosLast))
    else $error("result raised without a frame end");

  // Failed frames report zero readings
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && res_q.status != psfp_pkg::STATUS_OK) |->
      (res_q.first_value == '0 && res_q.second_value == '0 && res_q.third_value == '0))
    else $error("nonzero readings on a failed frame");

  // Collection always runs from byte 2 onward
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == psfp_pkg::MODE_COLLECT) |-> (pos_q >= psfp_pkg::PosFirstData))
    else $error("byte position below first data byte while collecting");

  // No byte is consumed while a result is stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_ready_i) |-> !take_o)
    else $error("byte consumed while result stalled");

endmodule

[tb/particle_sensor_frame_parser_unit_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for particle_sensor_frame_parser_unit: link bytes, offset writes
// and result back-pressure, with each frame result checked against a behavioral tracker.
// Depends on psfp_pkg and the parser RTL only.
module particle_sensor_frame_parser_unit_tb;

  localparam int         HalfPeriod    = 10;
  localparam int         ResetCycles   = 11;
  localparam int         SettleCycles  = 4;
  localparam int         WatchdogLimit = 2000;
  localparam int         HoldOffCycles = 300;
  localparam int         RandomBytes   = 1000;
  localparam int         MaxReports    = 10;
  localparam logic [1:0] CfgReserved   = 2'd3;

  // Payload fill for bytes 4..28 of a built frame
  typedef enum int {FILL_RANDOM, FILL_ONES, FILL_ZEROS} fill_e;

  // DUT ports
  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [7:0]  rx_byte_i   = 8'h00;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = 2'd0;
  logic [4:0]  cfg_wdata_i = 5'd0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  frame_status_o;
  logic [15:0] first_value_o;
  logic [15:0] second_value_o;
  logic [15:0] third_value_o;

  // Frame tracker state, mirrors the parser
  psfp_pkg::psfp_mode_e   scan_mode    = psfp_pkg::MODE_HUNT;
  int unsigned            scan_pos     = 0;
  logic [15:0]            frame_sum    = '0;
  logic [15:0]            frame_len    = '0;
  logic [7:0]             frame_err    = '0;
  logic [7:0]             frame_sum_hi = '0;
  logic [15:0]            reading_cap [3] = '{default: '0};
  logic [4:0]             reading_off [3] = '{psfp_pkg::FirstOffsetRst,
                                              psfp_pkg::SecondOffsetRst,
                                              psfp_pkg::ThirdOffsetRst};
  psfp_pkg::psfp_result_t awaited_frames [$];

  // Stimulus knobs and bookkeeping
  logic [7:0]   frame_buf [32];
  int unsigned  send_gap_max    = 0;
  int unsigned  recv_gap_max    = 0;
  int unsigned  hold_off_cycles = 0;
  int unsigned  bytes_accepted  = 0;
  int unsigned  frame_bytes     = 0;
  int unsigned  frames_checked  = 0;
  int unsigned  cfg_writes      = 0;
  int unsigned  mismatch_count  = 0;
  int unsigned  quiet_cycles    = 0;
  int unsigned  status_count [4] = '{default: 0};

  particle_sensor_frame_parser_unit i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .rx_byte_i      (rx_byte_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .frame_status_o (frame_status_o),
    .first_value_o  (first_value_o),
    .second_value_o (second_value_o),
    .third_value_o  (third_value_o)
  );

  // 20 ns clock
  always begin
    #HalfPeriod clk_i = 1'b1;
    #HalfPeriod clk_i = 1'b0;
  end

  // Merge one byte into a big-endian reading whose high byte sits at off
  function automatic logic [15:0] merge_reading(logic [15:0] cap, logic [4:0] off,
                                                int unsigned pos, logic [7:0] b);
    logic [15:0] r;
    int unsigned o;
    r = cap;
    o = off;
    if (pos == o) r[15:8] = b;
    if (pos == o + 1) r[7:0] = b;
    return r;
  endfunction

  function automatic void capture_readings(int unsigned pos, logic [7:0] b);
    int k;
    for (k = 0; k < 3; k++) reading_cap[k] = merge_reading(reading_cap[k], reading_off[k], pos, b);
  endfunction

  // Advance the tracker by one accepted byte; queue the frame result after byte 31
  function automatic void track_frame_byte(logic [7:0] b);
    psfp_pkg::psfp_result_t res;
    logic [15:0]            check;
    int                     k;
    case (scan_mode)
      psfp_pkg::MODE_HUNT: begin
        if (b == psfp_pkg::StartFirst) scan_mode = psfp_pkg::MODE_WAIT;
      end
      psfp_pkg::MODE_WAIT: begin
        if (b == psfp_pkg::StartSecond) begin
          scan_mode = psfp_pkg::MODE_COLLECT;
          for (k = 0; k < 3; k++) reading_cap[k] = '0;
          capture_readings(0, psfp_pkg::StartFirst);
          capture_readings(1, psfp_pkg::StartSecond);
          frame_sum    = 16'(psfp_pkg::StartFirst) + 16'(psfp_pkg::StartSecond);
          frame_len    = '0;
          frame_err    = '0;
          frame_sum_hi = '0;
          scan_pos     = 2;
        end else if (b != psfp_pkg::StartFirst) begin
          scan_mode = psfp_pkg::MODE_HUNT;
        end
      end
      default: begin
        capture_readings(scan_pos, b);
        if (scan_pos <= psfp_pkg::PosErr) frame_sum = frame_sum + 16'(b);
        if (scan_pos == psfp_pkg::PosLenHigh) frame_len[15:8] = b;
        else if (scan_pos == psfp_pkg::PosLenLow) frame_len[7:0] = b;
        else if (scan_pos == psfp_pkg::PosErr) frame_err = b;
        else if (scan_pos == psfp_pkg::PosSumHigh) frame_sum_hi = b;
        if (scan_pos == psfp_pkg::PosLast) begin
          check = {frame_sum_hi, b};
          // length first, then checksum, then the sensor's own error byte
          if (frame_len != psfp_pkg::GoodLength) res.status = psfp_pkg::STATUS_BAD_LENGTH;
          else if (frame_sum != check) res.status = psfp_pkg::STATUS_BAD_SUM;
          else if (frame_err != psfp_pkg::NoError) res.status = psfp_pkg::STATUS_SENSOR_ERR;
          else res.status = psfp_pkg::STATUS_OK;
          res.first_value  = (res.status == psfp_pkg::STATUS_OK) ? reading_cap[0] : 16'h0000;
          res.second_value = (res.status == psfp_pkg::STATUS_OK) ? reading_cap[1] : 16'h0000;
          res.third_value  = (res.status == psfp_pkg::STATUS_OK) ? reading_cap[2] : 16'h0000;
          awaited_frames.push_back(res);
          status_count[int'(res.status)]++;
          scan_mode = psfp_pkg::MODE_HUNT;
          scan_pos  = 0;
        end else begin
          scan_pos++;
        end
      end
    endcase
  endfunction

  // Fill frame_buf with one 32-byte frame whose parse outcome is the status kind names
  function automatic void build_frame(psfp_pkg::psfp_status_e kind, fill_e fill);
    logic [15:0] len;
    logic [15:0] sum;
    int          k;
    len = psfp_pkg::GoodLength;
    if (kind == psfp_pkg::STATUS_BAD_LENGTH) begin
      do
        len = ($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'($urandom_range(0, 255));
      while (len == psfp_pkg::GoodLength);
    end
    frame_buf[0] = psfp_pkg::StartFirst;
    frame_buf[1] = psfp_pkg::StartSecond;
    frame_buf[2] = len[15:8];
    frame_buf[3] = len[7:0];
    for (k = 4; k < 29; k++) begin
      case (fill)
        FILL_ONES:  frame_buf[k] = 8'hFF;
        FILL_ZEROS: frame_buf[k] = 8'h00;
        default:    frame_buf[k] = 8'($urandom);
      endcase
    end
    // lower-priority faults are piled onto failing frames now and then
    frame_buf[29] = psfp_pkg::NoError;
    if (kind == psfp_pkg::STATUS_SENSOR_ERR ||
        (kind != psfp_pkg::STATUS_OK && $urandom_range(0, 1) == 1))
      frame_buf[29] = 8'($urandom_range(1, 255));
    sum = '0;
    for (k = 0; k < 30; k++) sum = sum + 16'(frame_buf[k]);
    if (kind == psfp_pkg::STATUS_BAD_SUM ||
        (kind == psfp_pkg::STATUS_BAD_LENGTH && $urandom_range(0, 1) == 1))
      sum = sum + 16'($urandom_range(1, 65535));
    frame_buf[30] = sum[15:8];
    frame_buf[31] = sum[7:0];
  endfunction

  function automatic logic [4:0] pick_offset();
    case ($urandom_range(0, 5))
      0:       return 5'd0;
      1:       return 5'd30;
      2:       return 5'd31;
      default: return 5'($urandom_range(0, 31));
    endcase
  endfunction

  function automatic int unsigned pick_gap_max();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 3;
      default: return 14;
    endcase
  endfunction

  function automatic psfp_pkg::psfp_status_e random_kind();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return psfp_pkg::STATUS_OK;
      5, 6:          return psfp_pkg::STATUS_BAD_LENGTH;
      7:             return psfp_pkg::STATUS_BAD_SUM;
      default:       return psfp_pkg::STATUS_SENSOR_ERR;
    endcase
  endfunction

  // One input transaction after a random idle gap; valid stays up afterwards
  task automatic send_byte(logic [7:0] b);
    int unsigned gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    track_frame_byte(b);
    bytes_accepted++;
  endtask

  task automatic send_frame(psfp_pkg::psfp_status_e kind, fill_e fill);
    int k;
    build_frame(kind, fill);
    for (k = 0; k < 32; k++) send_byte(frame_buf[k]);
    frame_bytes += 32;
  endtask

  // One config transaction; valid is left high for a following write
  task automatic cfg_write(logic [1:0] idx, logic [4:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx != CfgReserved) reading_off[idx] = val;
    cfg_writes++;
  endtask

  // All three offsets, plus a write to the unused index that must be ignored
  task automatic program_offsets(logic [4:0] first_off, logic [4:0] second_off,
                                 logic [4:0] third_off);
    cfg_write(psfp_pkg::CfgFirstOffset, first_off);
    cfg_write(psfp_pkg::CfgSecondOffset, second_off);
    cfg_write(psfp_pkg::CfgThirdOffset, third_off);
    cfg_write(CfgReserved, 5'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  // Stop sending, wait out every pending result, then let the pipeline settle
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (awaited_frames.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic test_start_hunting();
    // ignored bytes at both extremes, a lone second start byte, a broken start pair
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(psfp_pkg::StartSecond);
    send_byte(psfp_pkg::StartFirst);
    send_byte(8'hFF);
    // repeated first start byte keeps waiting for the second one
    send_byte(psfp_pkg::StartFirst);
    send_byte(psfp_pkg::StartFirst);
    send_frame(psfp_pkg::STATUS_OK, FILL_RANDOM);
  endtask

  task automatic test_frame_statuses();
    send_frame(psfp_pkg::STATUS_OK, FILL_ONES);
    send_frame(psfp_pkg::STATUS_OK, FILL_ZEROS);
    send_frame(psfp_pkg::STATUS_BAD_LENGTH, FILL_RANDOM);
    send_frame(psfp_pkg::STATUS_BAD_SUM, FILL_RANDOM);
    send_frame(psfp_pkg::STATUS_SENSOR_ERR, FILL_RANDOM);
  endtask

  task automatic test_offset_extremes();
    // start bytes as readings, and offset 31 whose low byte lies past the frame
    drain_results();
    program_offsets(5'd0, 5'd1, 5'd31);
    send_frame(psfp_pkg::STATUS_OK, FILL_RANDOM);
    // odd offsets and the last full pair
    drain_results();
    program_offsets(5'd30, 5'd29, 5'd3);
    send_frame(psfp_pkg::STATUS_OK, FILL_ONES);
    drain_results();
    program_offsets(5'd31, 5'd30, 5'd0);
    send_frame(psfp_pkg::STATUS_OK, FILL_RANDOM);
  endtask

  task automatic test_midframe_config();
    int k;
    drain_results();
    program_offsets(psfp_pkg::FirstOffsetRst, psfp_pkg::SecondOffsetRst,
                    psfp_pkg::ThirdOffsetRst);
    build_frame(psfp_pkg::STATUS_OK, FILL_RANDOM);
    for (k = 0; k < 12; k++) send_byte(frame_buf[k]);
    // parser sits mid-frame; new offsets only affect bytes still to come
    drain_results();
    program_offsets(5'd11, 5'd20, 5'd6);
    for (k = 12; k < 32; k++) send_byte(frame_buf[k]);
    frame_bytes += 32;
  endtask

  task automatic test_backpressure();
    drain_results();
    send_gap_max    = 0;
    recv_gap_max    = 0;
    hold_off_cycles = HoldOffCycles;
    repeat (3) send_frame(psfp_pkg::STATUS_OK, FILL_RANDOM);
    // sender holds until every outstanding result is out
    drain_results();
  endtask

  task automatic test_random_traffic();
    int unsigned start_bytes;
    int unsigned pick;
    int unsigned cut;
    int          k;
    start_bytes = frame_bytes;
    while (frame_bytes - start_bytes < RandomBytes) begin
      drain_results();
      program_offsets(pick_offset(), pick_offset(), pick_offset());
      send_gap_max = pick_gap_max();
      recv_gap_max = pick_gap_max();
      repeat (8) begin
        pick = $urandom_range(0, 19);
        if (pick < 12) begin
          send_frame(random_kind(), FILL_RANDOM);
        end else if (pick < 15) begin
          // line noise
          repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
        end else if (pick < 17) begin
          repeat ($urandom_range(1, 3)) send_byte(psfp_pkg::StartFirst);
          send_frame(random_kind(), FILL_RANDOM);
        end else if (pick < 18) begin
          send_byte(psfp_pkg::StartFirst);
          send_byte(8'($urandom));
        end else begin
          // truncated frame, the next bytes finish it
          build_frame(psfp_pkg::STATUS_OK, FILL_RANDOM);
          cut = $urandom_range(2, 30);
          for (k = 0; k < cut; k++) send_byte(frame_buf[k]);
          frame_bytes += cut;
        end
      end
    end
  endtask

  // Result side: random stall after a result shows up, or one long hold-off on request
  initial begin : result_sink
    int unsigned stall;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_off_cycles != 0) begin
        out_ready_i <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk_i);
        hold_off_cycles = 0;
      end else if (recv_gap_max != 0) begin
        out_ready_i <= 1'b0;
        do @(posedge clk_i); while (!out_valid_o && hold_off_cycles == 0);
        stall = $urandom_range(0, recv_gap_max);
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o && hold_off_cycles == 0);
    end
  end

  // Compare each result transaction with the oldest pending frame
  always @(posedge clk_i) begin : frame_check
    psfp_pkg::psfp_result_t exp_frame;
    if (rst_ni && out_valid_o && out_ready_i) begin
      frames_checked++;
      if (awaited_frames.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MaxReports)
          $display("%0t: unexpected result: status %0d values %h %h %h", $time,
                   frame_status_o, first_value_o, second_value_o, third_value_o);
      end else begin
        exp_frame = awaited_frames.pop_front();
        if (frame_status_o !== exp_frame.status || first_value_o !== exp_frame.first_value ||
            second_value_o !== exp_frame.second_value ||
            third_value_o !== exp_frame.third_value) begin
          mismatch_count++;
          if (mismatch_count <= MaxReports)
            $display("%0t: mismatch: expected status %0d values %h %h %h, got %0d %h %h %h",
                     $time, exp_frame.status, exp_frame.first_value,
                     exp_frame.second_value, exp_frame.third_value, frame_status_o,
                     first_value_o, second_value_o, third_value_o);
        end
      end
    end
  end

  // Watchdog: too long without any transaction on any channel
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("FAIL particle_sensor_frame_parser_unit");
        $finish;
      end
    end
  end

  // Test sequence
  initial begin
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_gap_max = 14;
    recv_gap_max = 14;
    test_start_hunting();
    test_frame_statuses();
    test_offset_extremes();
    test_midframe_config();
    test_backpressure();
    test_random_traffic();
    drain_results();
    $display("Sent %0d link bytes (%0d inside frames), %0d register writes, %0d results checked",
             bytes_accepted, frame_bytes, cfg_writes, frames_checked);
    $display("Outcomes: ok %0d, bad length %0d, bad checksum %0d, sensor error %0d; %0d mismatches",
             status_count[int'(psfp_pkg::STATUS_OK)],
             status_count[int'(psfp_pkg::STATUS_BAD_LENGTH)],
             status_count[int'(psfp_pkg::STATUS_BAD_SUM)],
             status_count[int'(psfp_pkg::STATUS_SENSOR_ERR)],
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("PASS particle_sensor_frame_parser_unit");
    end else begin
      $display("FAIL particle_sensor_frame_parser_unit");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/psfp_pkg.sv
rtl/core/psfp_cfg_regs.sv
rtl/core/psfp_in_stage.sv
rtl/core/psfp_frame_core.sv
rtl/core/particle_sensor_frame_parser_unit.sv
tb/particle_sensor_frame_parser_unit_tb.sv
